[rtl/pts_pkg.sv]
// shared types, codes and helpers of the priority task scheduler
`default_nettype none

package pts_pkg;

    localparam int MAX_TASKS          = 32;
    localparam int DEF_NUM_TASKS      = 8;
    localparam int DEF_NUM_SEMAPHORES = 4;
    localparam int INIT_REGS          = 4;
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 8;
    localparam int SEM_W              = 8;
    localparam int FIND_IDX_W         = $clog2(MAX_TASKS);

    typedef enum logic [2:0] {
        ACT_START     = 3'd0,
        ACT_POST      = 3'd1,
        ACT_PEND      = 3'd2,
        ACT_IRQ_ENTER = 3'd3,
        ACT_IRQ_EXIT  = 3'd4
    } pts_action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TASK_COUNT = 3'd0,
        CFG_SEM0_INIT  = 3'd1,
        CFG_SEM1_INIT  = 3'd2,
        CFG_SEM2_INIT  = 3'd3,
        CFG_SEM3_INIT  = 3'd4
    } pts_cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCHED,
        ST_DONE
    } pts_state_t;

    typedef struct packed {
        logic [2:0] action;
        logic [1:0] sem_id;
    } pts_cmd_t;

    typedef struct packed {
        logic [2:0]              running_task;
        logic                    switched;
        logic                    deferred;
        logic                    no_ready_task;
        logic signed [SEM_W-1:0] sem_count;
    } pts_result_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic sched;
    } pts_ctrl_t;

    typedef struct packed {
        logic                  found;
        logic [FIND_IDX_W-1:0] idx;
    } pts_find_t;

    // highest set bit of a slot vector
    function automatic pts_find_t find_top(logic [MAX_TASKS-1:0] vec);
        pts_find_t res;
        res.found = 1'b0;
        res.idx   = '0;
        for (int i = 0; i < MAX_TASKS; i++) begin
            if (vec[i])
            begin
                res.found = 1'b1;
                res.idx   = FIND_IDX_W'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/pts_ctrl.sv]
// event sequencer of the priority task scheduler
`default_nettype none

module pts_ctrl
    import pts_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    output logic           done,
    output pts_ctrl_t      ctrl
);

    pts_state_t state_reg;
    pts_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctrl.exec  = 1'b1;
                state_next = ST_SCHED;
            end
            ST_SCHED:
            begin
                ctrl.sched = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/pts_datapath.sv]
// task, semaphore and interrupt-depth state with the event and reschedule logic
`default_nettype none

module pts_datapath
    import pts_pkg::*;
#(
    parameter int NUM_TASKS      = DEF_NUM_TASKS,
    parameter int NUM_SEMAPHORES = DEF_NUM_SEMAPHORES
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire pts_ctrl_t              ctrl,
    input  wire pts_cmd_t               cmd,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output pts_result_t                 result
);

    localparam int TW = $clog2(NUM_TASKS);
    localparam int SW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;

    // configuration
    logic [3:0]       task_count_reg;
    logic [SEM_W-1:0] sem_init_reg [INIT_REGS];

    // scheduler state
    logic [NUM_TASKS-1:0] waiting_reg;
    logic [1:0]           wait_sem_reg [NUM_TASKS];
    logic [SEM_W-1:0]     sem_value_reg [NUM_SEMAPHORES];
    logic [TW-1:0]        current_reg;
    logic [7:0]           isr_depth_reg;
    logic                 need_sched_reg;

    pts_cmd_t    cmd_reg;
    pts_result_t result_reg;

    logic [SW-1:0]        sem_idx;
    logic                 sem_ok;
    logic [SEM_W-1:0]     sem_old;
    logic [NUM_TASKS-1:0] in_use;
    logic [MAX_TASKS-1:0] wake_vec;
    logic [MAX_TASKS-1:0] ready_vec;
    pts_find_t            wake_f;
    pts_find_t            ready_f;
    logic                 blocks;
    logic                 sched_run;

    assign sem_idx = SW'(cmd_reg.sem_id);
    assign sem_ok  = int'(cmd_reg.sem_id) < NUM_SEMAPHORES;
    assign sem_old = sem_value_reg[sem_idx];
    assign blocks  = (sem_old == '0) || sem_old[SEM_W-1];

    always_comb
    begin
        wake_vec  = '0;
        ready_vec = '0;
        for (int i = 0; i < NUM_TASKS; i++) begin
            // a task count of zero still keeps the idle slot
            in_use[i]    = (i == 0) || (i < int'(task_count_reg));
            wake_vec[i]  = in_use[i] && waiting_reg[i] && (wait_sem_reg[i] == cmd_reg.sem_id);
            ready_vec[i] = in_use[i] && !waiting_reg[i];
        end
        wake_f  = find_top(wake_vec);
        ready_f = find_top(ready_vec);
    end

    assign sched_run = need_sched_reg && (isr_depth_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= 4'd1;
            for (int i = 0; i < INIT_REGS; i++) begin
                sem_init_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TASK_COUNT: task_count_reg  <= cfg_data[3:0];
                CFG_SEM0_INIT:  sem_init_reg[0] <= cfg_data;
                CFG_SEM1_INIT:  sem_init_reg[1] <= cfg_data;
                CFG_SEM2_INIT:  sem_init_reg[2] <= cfg_data;
                CFG_SEM3_INIT:  sem_init_reg[3] <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg    <= '0;
            current_reg    <= '0;
            isr_depth_reg  <= '0;
            need_sched_reg <= 1'b0;
            for (int i = 0; i < NUM_TASKS; i++) begin
                wait_sem_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_SEMAPHORES; i++) begin
                sem_value_reg[i] <= '0;
            end
        end
        else if (ctrl.exec)
        begin
            need_sched_reg <= 1'b0;
            unique case (cmd_reg.action)
                ACT_START:
                begin
                    for (int i = 0; i < NUM_SEMAPHORES; i++) begin
                        sem_value_reg[i] <= (i < INIT_REGS) ? sem_init_reg[i % INIT_REGS] : '0;
                    end
                    waiting_reg <= '0;
                    for (int i = 0; i < NUM_TASKS; i++) begin
                        wait_sem_reg[i] <= '0;
                    end
                    need_sched_reg <= 1'b1;
                end
                ACT_POST:
                begin
                    if (sem_ok)
                    begin
                        sem_value_reg[sem_idx] <= sem_old + 1'b1;
                        if (wake_f.found)
                        begin
                            waiting_reg[wake_f.idx[TW-1:0]] <= 1'b0;
                            need_sched_reg                  <= 1'b1;
                        end
                    end
                end
                ACT_PEND:
                begin
                    if (sem_ok)
                    begin
                        sem_value_reg[sem_idx] <= sem_old - 1'b1;
                        if (blocks)
                        begin
                            waiting_reg[current_reg]  <= 1'b1;
                            wait_sem_reg[current_reg] <= cmd_reg.sem_id;
                            need_sched_reg            <= 1'b1;
                        end
                    end
                end
                ACT_IRQ_ENTER:
                begin
                    if (isr_depth_reg != 8'hFF)
                    begin
                        isr_depth_reg <= isr_depth_reg + 1'b1;
                    end
                end
                ACT_IRQ_EXIT:
                begin
                    if (isr_depth_reg != 8'h00)
                    begin
                        isr_depth_reg <= isr_depth_reg - 1'b1;
                    end
                    need_sched_reg <= 1'b1;
                end
                default: ;
            endcase
        end
        else if (ctrl.sched)
        begin
            if (sched_run && ready_f.found)
            begin
                current_reg <= ready_f.idx[TW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= cmd;
        end
        if (ctrl.sched)
        begin
            result_reg.running_task  <= (sched_run && ready_f.found) ?
                                        3'(ready_f.idx[TW-1:0]) : 3'(current_reg);
            result_reg.switched      <= sched_run && ready_f.found &&
                                        (ready_f.idx[TW-1:0] != current_reg);
            result_reg.deferred      <= need_sched_reg && (isr_depth_reg != '0);
            result_reg.no_ready_task <= sched_run && !ready_f.found;
            result_reg.sem_count     <= sem_ok ? sem_value_reg[sem_idx] : '0;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

[rtl/priority_task_scheduler_semaphores.sv]
// top level of the priority task scheduler with counting semaphores
//
//  channel  | handshake          | payload                 | direction
//  ---------+--------------------+-------------------------+----------
//  event    | start / busy       | cmd (action, sem_id)    | in
//  result   | done strobe        | result (pts_result_t)   | out
//  config   | cfg_we             | cfg_index, cfg_data     | in
//
//  an event transaction is taken when start is high and busy is low
//  every event runs through four steps: accept, apply event, reschedule, result strobe
//  the steps are set by the sequencer, one step per registered stage
//  done is high for one cycle; the result cannot be held off
//  rst_n clears all task, semaphore and interrupt-depth state at once
`default_nettype none

module priority_task_scheduler_semaphores
    import pts_pkg::*;
#(
    parameter int NUM_TASKS      = DEF_NUM_TASKS,
    parameter int NUM_SEMAPHORES = DEF_NUM_SEMAPHORES
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire pts_cmd_t               cmd,
    output logic                        done,
    output pts_result_t                 result,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    pts_ctrl_t ctrl;

    pts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctrl  (ctrl)
    );

    pts_datapath #(
        .NUM_TASKS      (NUM_TASKS),
        .NUM_SEMAPHORES (NUM_SEMAPHORES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

`default_nettype wire

[rtl/pts_checker.sv]
// port-level checks of the priority task scheduler and their bind
`default_nettype none

module pts_checker
    import pts_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   start,
    input wire logic                   busy,
    input wire pts_cmd_t               cmd,
    input wire logic                   done,
    input wire pts_result_t            result,
    input wire logic                   cfg_we,
    input wire logic [CFG_INDEX_W-1:0] cfg_index,
    input wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // every accepted transaction returns its result once the apply-event and reschedule states have passed
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result strobe missing after accepted event");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted event");

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy ##1 (!busy && !done))
        else $error("block not free after result strobe");

    // a reschedule ends in at most one of switched, deferred, no ready slot
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot0({result.switched, result.deferred, result.no_ready_task}))
        else $error("conflicting reschedule flags");

endmodule

bind priority_task_scheduler_semaphores pts_checker u_pts_checker (.*);

`default_nettype wire

[tb/pts_result_check.sv]
// result checker: predicts scheduler outcomes from observed transactions and compares them
`timescale 1ns / 100ps

module pts_result_check
    import pts_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic                   busy,
    input  wire pts_cmd_t               cmd,
    input  wire logic                   done,
    input  wire pts_result_t            result,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output int unsigned                 mismatches,
    output int unsigned                 outstanding
);

    localparam int REPORT_LIMIT = 10;

    // scheduler state as seen from outside
    logic [3:0]              cfg_tasks;
    logic signed [SEM_W-1:0] cfg_sem_init [INIT_REGS];
    logic                    slot_blocked [DEF_NUM_TASKS];
    logic [1:0]              slot_sem     [DEF_NUM_TASKS];
    logic signed [SEM_W-1:0] sem_level    [DEF_NUM_SEMAPHORES];
    logic [2:0]              run_slot;
    logic [7:0]              irq_nest;

    pts_result_t pending_outcomes [$];

    function automatic int live_slots();
        if (cfg_tasks == 4'd0)
            return 1;
        if (int'(cfg_tasks) > DEF_NUM_TASKS)
            return DEF_NUM_TASKS;
        return int'(cfg_tasks);
    endfunction

    function automatic void pick_runner(inout pts_result_t r);
        int n;
        n = live_slots();
        if (irq_nest != 8'd0)
        begin
            r.deferred = 1'b1;
            return;
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            if (!slot_blocked[i])
            begin
                if (i[2:0] != run_slot)
                begin
                    run_slot   = i[2:0];
                    r.switched = 1'b1;
                end
                return;
            end
        end
        r.no_ready_task = 1'b1;
    endfunction

    function automatic pts_result_t next_outcome(pts_cmd_t c);
        pts_result_t             r;
        logic signed [SEM_W-1:0] prior;
        int                      n;
        r = '0;
        case (c.action)
            ACT_START:
            begin
                for (int s = 0; s < DEF_NUM_SEMAPHORES; s++)
                    sem_level[s] = cfg_sem_init[s];
                for (int i = 0; i < DEF_NUM_TASKS; i++)
                begin
                    slot_blocked[i] = 1'b0;
                    slot_sem[i]     = 2'd0;
                end
                pick_runner(r);
            end
            ACT_POST:
            begin
                sem_level[c.sem_id] = sem_level[c.sem_id] + 8'sd1;
                n = live_slots();
                // only the highest waiter on this semaphore wakes
                for (int i = n - 1; i >= 0; i--)
                begin
                    if (slot_blocked[i] && slot_sem[i] == c.sem_id)
                    begin
                        slot_blocked[i] = 1'b0;
                        pick_runner(r);
                        break;
                    end
                end
            end
            ACT_PEND:
            begin
                prior = sem_level[c.sem_id];
                sem_level[c.sem_id] = prior - 8'sd1;
                if (prior <= 0)
                begin
                    slot_blocked[run_slot] = 1'b1;
                    slot_sem[run_slot]     = c.sem_id;
                    pick_runner(r);
                end
            end
            ACT_IRQ_ENTER:
            begin
                if (irq_nest != 8'hFF)
                    irq_nest = irq_nest + 8'd1;
            end
            ACT_IRQ_EXIT:
            begin
                if (irq_nest != 8'd0)
                    irq_nest = irq_nest - 8'd1;
                pick_runner(r);
            end
            default:
            begin
            end
        endcase
        r.running_task = run_slot;
        r.sem_count    = sem_level[c.sem_id];
        return r;
    endfunction

    function automatic void note_mismatch(pts_result_t want, pts_result_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t mismatch: expected task=%0d sw=%0b dfr=%0b none=%0b sem=%0d, got task=%0d sw=%0b dfr=%0b none=%0b sem=%0d",
                     $realtime, want.running_task, want.switched, want.deferred,
                     want.no_ready_task, want.sem_count, got.running_task, got.switched,
                     got.deferred, got.no_ready_task, got.sem_count);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pts_result_t want;
        if (!rst_n)
        begin
            cfg_tasks = 4'd1;
            for (int s = 0; s < INIT_REGS; s++)
                cfg_sem_init[s] = '0;
            for (int i = 0; i < DEF_NUM_TASKS; i++)
            begin
                slot_blocked[i] = 1'b0;
                slot_sem[i]     = 2'd0;
            end
            for (int s = 0; s < DEF_NUM_SEMAPHORES; s++)
                sem_level[s] = '0;
            run_slot   = 3'd0;
            irq_nest   = 8'd0;
            pending_outcomes.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TASK_COUNT: cfg_tasks       = cfg_data[3:0];
                    CFG_SEM0_INIT:  cfg_sem_init[0] = cfg_data;
                    CFG_SEM1_INIT:  cfg_sem_init[1] = cfg_data;
                    CFG_SEM2_INIT:  cfg_sem_init[2] = cfg_data;
                    CFG_SEM3_INIT:  cfg_sem_init[3] = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (done)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t result strobe with no transaction pending", $realtime);
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (result.running_task !== want.running_task ||
                        result.switched !== want.switched ||
                        result.deferred !== want.deferred ||
                        result.no_ready_task !== want.no_ready_task ||
                        result.sem_count !== want.sem_count)
                        note_mismatch(want, result);
                end
            end
            if (start && !busy)
                pending_outcomes.push_back(next_outcome(cmd));
            outstanding = pending_outcomes.size();
        end
    end

endmodule

[tb/priority_task_scheduler_semaphores_tb.sv]
// testbench top: clock, reset, register phases and scheduler event stimulus
`timescale 1ns / 100ps

module priority_task_scheduler_semaphores_tb;
    import pts_pkg::*;

    localparam int          HANG_LIMIT      = 1000;
    localparam int          PHASE_EVENTS    = 100;
    localparam int          NEST_OVERRUN    = 260;
    localparam logic [2:0]  ACT_RSVD_FIRST  = 3'd5;
    localparam logic [2:0]  ACT_RSVD_LAST   = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    pts_cmd_t               cmd;
    logic                   done;
    pts_result_t            result;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int unsigned            mismatches;
    int unsigned            outstanding;
    bit                     gaps_on;
    int                     stall_cycles;

    priority_task_scheduler_semaphores u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pts_result_check u_result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .result      (result),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #10 clk = ~clk;

    // start stays high across back-to-back transactions, new command at the falling edge
    task automatic fire(input logic [2:0] act, input logic [1:0] sid);
        if (gaps_on && $urandom_range(0, 99) < 38)
        begin
            @(negedge clk);
            start <= 1'b0;
            // let the block go free first so the gap shows up at its input
            while (busy)
                @(negedge clk);
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
        @(negedge clk);
        start       <= 1'b1;
        cmd.action  <= act;
        cmd.sem_id  <= sid;
        do @(posedge clk); while (busy);
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input pts_cfg_index_t idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(input logic [3:0] tasks, input logic [7:0] s0,
                             input logic [7:0] s1, input logic [7:0] s2,
                             input logic [7:0] s3);
        drain();
        // upper nibble of the task count write is don't-care
        write_reg(CFG_TASK_COUNT, {4'($urandom_range(0, 15)), tasks});
        write_reg(CFG_SEM0_INIT, s0);
        write_reg(CFG_SEM1_INIT, s1);
        write_reg(CFG_SEM2_INIT, s2);
        write_reg(CFG_SEM3_INIT, s3);
    endtask

    function automatic logic [7:0] pick_init();
        case ($urandom_range(0, 5))
            0:       return 8'h80;
            1:       return 8'h7F;
            2:       return 8'h00;
            3:       return 8'hFF;
            4:       return 8'h01;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_event();
        int unsigned roll;
        logic [1:0]  sid;
        roll = $urandom_range(0, 99);
        sid  = 2'($urandom_range(0, 3));
        if (roll < 35)
            fire(ACT_PEND, sid);
        else if (roll < 70)
            fire(ACT_POST, sid);
        else if (roll < 79)
            fire(ACT_IRQ_ENTER, sid);
        else if (roll < 91)
            fire(ACT_IRQ_EXIT, sid);
        else if (roll < 96)
            fire(ACT_START, sid);
        else
            fire(3'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST)), sid);
    endtask

    // hang detection: cycles with no transaction of any kind
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < HANG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [3:0] task_choices [8];
        task_choices = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd5, 4'd0, 4'd9, 4'd2};
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        gaps_on   = 1'b1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: wrap, blocking chains, wake order, nesting, unused codes
        configure(4'd8, 8'h00, 8'h7F, 8'h80, 8'hFF);
        fire(ACT_START, 2'd0);
        fire(ACT_PEND, 2'd0);
        fire(ACT_PEND, 2'd0);
        fire(ACT_POST, 2'd0);
        fire(ACT_POST, 2'd1);
        fire(ACT_PEND, 2'd1);
        fire(ACT_PEND, 2'd2);
        fire(ACT_POST, 2'd3);
        fire(ACT_IRQ_ENTER, 2'd3);
        fire(ACT_PEND, 2'd3);
        fire(ACT_IRQ_ENTER, 2'd0);
        fire(ACT_IRQ_EXIT, 2'd1);
        fire(ACT_IRQ_EXIT, 2'd2);
        fire(ACT_IRQ_EXIT, 2'd3);
        fire(ACT_POST, 2'd1);
        fire(ACT_POST, 2'd0);
        fire(ACT_RSVD_FIRST, 2'd3);
        fire(ACT_RSVD_FIRST + 3'd1, 2'd2);
        fire(ACT_RSVD_LAST, 2'd1);
        fire(ACT_POST, 2'd2);
        fire(ACT_IRQ_ENTER, 2'd0);
        fire(ACT_START, 2'd2);
        fire(ACT_IRQ_EXIT, 2'd0);

        // zero task count acts as one slot; idle slot blocks with nothing ready
        configure(4'd0, 8'h00, 8'h80, 8'h7F, 8'h01);
        fire(ACT_START, 2'd0);
        fire(ACT_PEND, 2'd0);
        fire(ACT_POST, 2'd0);

        for (int p = 0; p < 8; p++)
        begin
            configure(task_choices[p], pick_init(), pick_init(), pick_init(), pick_init());
            gaps_on = (p != 5);
            fire(ACT_START, 2'($urandom_range(0, 3)));
            for (int k = 0; k < PHASE_EVENTS; k++)
            begin
                if (p == 1 && k == PHASE_EVENTS / 2)
                    drain();
                random_event();
            end
            if (p == 3)
            begin
                // interrupt nesting past saturation and back down past zero
                for (int k = 0; k < NEST_OVERRUN; k++)
                    fire(ACT_IRQ_ENTER, 2'($urandom_range(0, 3)));
                for (int k = 0; k < 6; k++)
                    random_event();
                for (int k = 0; k < NEST_OVERRUN; k++)
                    fire(ACT_IRQ_EXIT, 2'($urandom_range(0, 3)));
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
